>>> rtl/wrr_pkg.sv
// wrr_pkg: shared constants for the weighted round-robin selector
// used by the channel interfaces and the top level; no dependencies
package wrr_pkg;

    localparam int SLOTS_DEFAULT       = 8;
    localparam int WEIGHT_BITS_DEFAULT = 8;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 64;
    localparam int ENABLE_BITS    = 8;
    localparam int WEIGHTS_BITS   = 64;
    localparam int SLOT_BITS      = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOT_ENABLE  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOT_WEIGHTS = 8'd1;

    localparam logic [ENABLE_BITS-1:0]  ENABLE_RESET  = 8'h00;
    localparam logic [WEIGHTS_BITS-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;

    localparam logic STATUS_GRANTED = 1'b0;
    localparam logic STATUS_NONE    = 1'b1;

endpackage

>>> rtl/wrr_if.sv
// wrr_if: valid/ready channels for requests, results and register writes
// depends on wrr_pkg for payload widths
interface wrr_req_if;
    logic valid;
    logic ready;
    logic request_valid;

    modport source (output valid, output request_valid, input ready);
    modport sink (input valid, input request_valid, output ready);
endinterface

interface wrr_res_if;
    logic                          valid;
    logic                          ready;
    logic [wrr_pkg::SLOT_BITS-1:0] granted_slot;
    logic                          grant_status;
    logic                          refilled;

    modport source (output valid, output granted_slot, output grant_status,
                    output refilled, input ready);
    modport sink (input valid, input granted_slot, input grant_status,
                  input refilled, output ready);
endinterface

interface wrr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wrr_pkg::CFG_INDEX_BITS-1:0] index;
    logic [wrr_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/weighted_round_robin_selector.sv
// weighted_round_robin_selector: credit based weighted round-robin slot selector
// request beat to result beat through the input register, then the result register
// throughput one request per cycle unless res stalls; pick and credits update together
// reset: last grant 0, all credits 0, no slot enabled, every weight 1
// depends on wrr_pkg and the channel interfaces in wrr_if.sv
module weighted_round_robin_selector #(
    parameter int SLOTS       = wrr_pkg::SLOTS_DEFAULT,
    parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    wrr_req_if.sink       req,
    wrr_res_if.source     res,
    wrr_cfg_if.sink       cfg
);

    localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                               in_valid_reg;
    logic                               in_req_reg;
    logic [wrr_pkg::ENABLE_BITS-1:0]    enable_reg;
    logic [wrr_pkg::WEIGHTS_BITS-1:0]   weights_reg;
    logic [wrr_pkg::SLOT_BITS-1:0]      last_grant_reg;
    logic [wrr_pkg::SLOT_BITS-1:0]      last_grant_next;
    logic [WEIGHT_BITS-1:0]             credit_reg [SLOTS];
    logic [WEIGHT_BITS-1:0]             credit_next [SLOTS];
    logic                               out_valid_reg;
    logic [wrr_pkg::SLOT_BITS-1:0]      slot_reg;
    logic [wrr_pkg::SLOT_BITS-1:0]      slot_next;
    logic                               status_reg;
    logic                               status_next;
    logic                               refilled_reg;
    logic                               refilled_next;

    logic                               move;
    logic [SLOTS-1:0]                   member;
    logic [WEIGHT_BITS-1:0]             weight [SLOTS];
    logic [SLOTS-1:0]                   above;
    logic [SLOTS-1:0]                   below;
    logic [SLOTS-1:0]                   refill_ok;
    logic [IDX_BITS-1:0]                lg;
    logic [IDX_BITS-1:0]                above_idx;
    logic [IDX_BITS-1:0]                below_idx;
    logic [IDX_BITS-1:0]                scan_idx;
    logic [IDX_BITS-1:0]                refill_idx;
    logic                               scan_hit;
    logic                               refill_hit;

    assign move      = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || move;
    assign cfg.ready = 1'b1;

    assign res.valid        = out_valid_reg;
    assign res.granted_slot = slot_reg;
    assign res.grant_status = status_reg;
    assign res.refilled     = refilled_reg;

    assign member = SLOTS'({{SLOTS{1'b0}}, enable_reg});
    assign lg     = IDX_BITS'(last_grant_reg);

    // per-slot weight, credit and eligibility
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i * WEIGHT_BITS < wrr_pkg::WEIGHTS_BITS)
                weight[i] = WEIGHT_BITS'(weights_reg >> (i * WEIGHT_BITS));
            else
                weight[i] = '0;
            above[i]     = member[i] && (credit_reg[i] != '0) && (IDX_BITS'(i) > lg);
            below[i]     = member[i] && (credit_reg[i] != '0) && (IDX_BITS'(i) < lg);
            refill_ok[i] = member[i] && (weight[i] != '0);
        end
    end

    // lowest set bit of each candidate vector
    always_comb
    begin
        above_idx  = '0;
        below_idx  = '0;
        refill_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (above[i])
                above_idx = IDX_BITS'(i);
            if (below[i])
                below_idx = IDX_BITS'(i);
            if (refill_ok[i])
                refill_idx = IDX_BITS'(i);
        end
    end

    assign scan_hit   = (|above) || (|below);
    assign scan_idx   = (|above) ? above_idx : below_idx;
    assign refill_hit = |refill_ok;

    always_comb
    begin
        last_grant_next = last_grant_reg;
        slot_next       = '0;
        status_next     = wrr_pkg::STATUS_NONE;
        refilled_next   = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            credit_next[i] = credit_reg[i];

        if (move && in_req_reg)
        begin
            if (scan_hit)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (IDX_BITS'(i) == scan_idx)
                        credit_next[i] = credit_reg[i] - 1'b1;
                last_grant_next = wrr_pkg::SLOT_BITS'(scan_idx);
                slot_next       = wrr_pkg::SLOT_BITS'(scan_idx);
                status_next     = wrr_pkg::STATUS_GRANTED;
            end
            else
            begin
                refilled_next = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!member[i])
                        credit_next[i] = '0;
                    else if (refill_hit && (IDX_BITS'(i) == refill_idx))
                        credit_next[i] = weight[i] - 1'b1;
                    else
                        credit_next[i] = weight[i];
                end
                if (refill_hit)
                begin
                    last_grant_next = wrr_pkg::SLOT_BITS'(refill_idx);
                    slot_next       = wrr_pkg::SLOT_BITS'(refill_idx);
                    status_next     = wrr_pkg::STATUS_GRANTED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_grant_reg <= '0;
            enable_reg     <= wrr_pkg::ENABLE_RESET;
            weights_reg    <= wrr_pkg::WEIGHTS_RESET;
            for (int i = 0; i < SLOTS; i++)
                credit_reg[i] <= '0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (move)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid && cfg.index == wrr_pkg::CFG_SLOT_ENABLE)
                enable_reg <= cfg.data[wrr_pkg::ENABLE_BITS-1:0];
            if (cfg.valid && cfg.index == wrr_pkg::CFG_SLOT_WEIGHTS)
                weights_reg <= cfg.data;
            last_grant_reg <= last_grant_next;
            for (int i = 0; i < SLOTS; i++)
                credit_reg[i] <= credit_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            in_req_reg <= req.request_valid;
        if (move)
        begin
            slot_reg     <= slot_next;
            status_reg   <= status_next;
            refilled_reg <= refilled_next;
        end
    end

    a_none_is_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.grant_status == wrr_pkg::STATUS_NONE |-> res.granted_slot == '0)
        else $error("no-grant result carries a nonzero slot");

    a_grant_is_member: assert property (@(posedge clk) disable iff (!rst_n)
        move && status_next == wrr_pkg::STATUS_GRANTED |-> member[slot_next])
        else $error("grant to a slot that is not enabled");

    a_scan_skips_last: assert property (@(posedge clk) disable iff (!rst_n)
        move && status_next == wrr_pkg::STATUS_GRANTED && !refilled_next
        |-> slot_next != last_grant_reg)
        else $error("scan granted the last granted slot again");

    a_idle_keeps_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        !(move && in_req_reg) |=> $stable(last_grant_reg))
        else $error("grant pointer moved without a request");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !res.ready |-> !req.ready)
        else $error("input taken while both stages are full");

endmodule

>>> test/wrr_grant_checker.sv
// wrr_grant_checker: predicts the selector's grants from the request and register beats it sees
// and compares every result beat with the oldest prediction; depends on wrr_pkg and wrr_if.sv
module wrr_grant_checker #(
    parameter int SLOTS       = wrr_pkg::SLOTS_DEFAULT,
    parameter int WEIGHT_BITS = wrr_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    wrr_req_if   req,
    wrr_res_if   res,
    wrr_cfg_if   cfg,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [wrr_pkg::SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        slot_t slot;
        logic  status;
        logic  refill;
    } grant_t;

    logic [wrr_pkg::ENABLE_BITS-1:0]  member_mask;
    logic [wrr_pkg::WEIGHTS_BITS-1:0] weight_word;
    slot_t                            last_slot;
    logic [WEIGHT_BITS-1:0]           credits [SLOTS];
    grant_t                           expected_grants [$];

    function automatic bit is_member(int s);
        return s < wrr_pkg::ENABLE_BITS && member_mask[s];
    endfunction

    function automatic bit slot_ready(int s);
        return is_member(s) && credits[s] != '0;
    endfunction

    function automatic void spend_credit(int s);
        credits[s]  = credits[s] - 1'b1;
        last_slot   = slot_t'(s);
    endfunction

    function automatic grant_t predict_grant(logic asked);
        grant_t g;
        int     s;
        g.slot   = '0;
        g.status = wrr_pkg::STATUS_NONE;
        g.refill = 1'b0;
        if (!asked)
            return g;
        for (int k = 1; k < SLOTS; k++)
        begin
            s = (int'(last_slot) + k) % SLOTS;
            if (slot_ready(s))
            begin
                spend_credit(s);
                g.slot   = slot_t'(s);
                g.status = wrr_pkg::STATUS_GRANTED;
                return g;
            end
        end
        // nobody else holds credit: refill from weights, last grant's credit included
        g.refill = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (is_member(i) && i * WEIGHT_BITS < wrr_pkg::WEIGHTS_BITS)
                credits[i] = weight_word[i*WEIGHT_BITS +: WEIGHT_BITS];
            else
                credits[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_ready(i))
            begin
                spend_credit(i);
                g.slot   = slot_t'(i);
                g.status = wrr_pkg::STATUS_GRANTED;
                return g;
            end
        end
        return g;
    endfunction

    function automatic void check_field(string name, slot_t want, slot_t got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            member_mask = wrr_pkg::ENABLE_RESET;
            weight_word = wrr_pkg::WEIGHTS_RESET;
            last_slot   = '0;
            foreach (credits[i])
                credits[i] = '0;
            expected_grants.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == wrr_pkg::CFG_SLOT_ENABLE)
                    member_mask = cfg.data[wrr_pkg::ENABLE_BITS-1:0];
                else if (cfg.index == wrr_pkg::CFG_SLOT_WEIGHTS)
                    weight_word = cfg.data[wrr_pkg::WEIGHTS_BITS-1:0];
            end
            if (req.valid && req.ready)
                expected_grants = {expected_grants, predict_grant(req.request_valid)};
            if (res.valid && res.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: result beat expected none actual slot %0d status %0d refilled %0d",
                             $time, res.granted_slot, res.grant_status, res.refilled);
                    errors++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    check_field("granted_slot", want.slot, res.granted_slot);
                    check_field("grant_status", slot_t'(want.status), slot_t'(res.grant_status));
                    check_field("refilled", slot_t'(want.refill), slot_t'(res.refilled));
                end
            end
        end
        pending = expected_grants.size();
    end

endmodule

>>> test/tb_weighted_round_robin_selector.sv
// tb_weighted_round_robin_selector: drives request and register beats and stalls the result side
// of the weighted round-robin selector; prediction and checking live in wrr_grant_checker
// depends on wrr_pkg, wrr_if.sv, the selector RTL and wrr_grant_checker.sv
module tb_weighted_round_robin_selector;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [wrr_pkg::CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [wrr_pkg::ENABLE_BITS-1:0]    enable_t;

    localparam int REQUEST_TARGET = 800;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam cfg_index_t CFG_UNUSED_FIRST = 8'd2;
    localparam cfg_index_t CFG_UNUSED_LAST  = 8'hFF;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   requests_sent;
    int   idle_cycles;
    int   phase;
    bit   req_no_idle;
    bit   res_no_idle;
    bit   res_hold_due;

    wrr_req_if req_ch ();
    wrr_res_if res_ch ();
    wrr_cfg_if cfg_ch ();

    weighted_round_robin_selector u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    wrr_grant_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic write_reg(input cfg_index_t index,
                             input logic [wrr_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_request(input logic asked);
        int gap;
        gap = req_no_idle ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.request_valid <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.request_valid <= asked;
        do @(posedge clk); while (!req_ch.ready);
        requests_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic enable_t random_enable();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return enable_t'(1) << $urandom_range(0, wrr_pkg::ENABLE_BITS - 1);
            default: return enable_t'($urandom);
        endcase
    endfunction

    function automatic logic [wrr_pkg::WEIGHTS_BITS-1:0] random_weights();
        logic [wrr_pkg::WEIGHTS_BITS-1:0] w;
        for (int i = 0; i < wrr_pkg::WEIGHTS_BITS / wrr_pkg::WEIGHT_BITS_DEFAULT; i++)
        begin
            case ($urandom_range(0, 7))
                0:       w[i*8 +: 8] = 8'h00;
                1:       w[i*8 +: 8] = 8'hFF;
                2:       w[i*8 +: 8] = 8'($urandom);
                default: w[i*8 +: 8] = 8'($urandom_range(1, 3));
            endcase
        end
        return w;
    endfunction

    // result side: random stalls, one long hold-off when asked
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (res_hold_due)
            begin
                gap          = STALL_CYCLES;
                res_hold_due = 1'b0;
            end
            else
                gap = res_no_idle ? 0 : $urandom_range(0, 9);
            @(negedge clk);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.request_valid = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        req_no_idle          = 1'b0;
        res_no_idle          = 1'b0;
        res_hold_due         = 1'b0;
        requests_sent        = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no member slot: refill grants nothing; then an empty beat
        send_request(1'b1);
        send_request(1'b0);
        drain_results();

        // all members at reset weights: one full round, then refill
        write_reg(wrr_pkg::CFG_SLOT_ENABLE, 64'hFF);
        repeat (9) send_request(1'b1);
        drain_results();

        // mixed weights, zero and full scale, some members disabled with credit left
        write_reg(wrr_pkg::CFG_SLOT_WEIGHTS, 64'h8000_0300_00FF_0002);
        write_reg(wrr_pkg::CFG_SLOT_ENABLE, 64'hA5);
        repeat (6) send_request(1'b1);
        drain_results();

        // every weight zero: leftover credits, then nothing grantable
        write_reg(wrr_pkg::CFG_SLOT_WEIGHTS, 64'h0);
        write_reg(wrr_pkg::CFG_SLOT_ENABLE, 64'hFF);
        repeat (3) send_request(1'b1);
        drain_results();

        // writes to unused indexes change nothing
        write_reg(CFG_UNUSED_FIRST, '1);
        write_reg(CFG_UNUSED_LAST, '1);
        repeat (2) send_request(1'b1);
        drain_results();

        // single member: its own leftover credit is overwritten on each refill
        write_reg(wrr_pkg::CFG_SLOT_WEIGHTS, 64'h0200_0000_0000_0000);
        write_reg(wrr_pkg::CFG_SLOT_ENABLE, 64'hFFFF_FFFF_FFFF_FF80);
        repeat (3) send_request(1'b1);

        phase = 0;
        while (requests_sent < REQUEST_TARGET)
        begin
            drain_results();
            if ($urandom_range(0, 3) == 0)
                write_reg(cfg_index_t'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                          {$urandom, $urandom});
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(wrr_pkg::CFG_SLOT_ENABLE, {$urandom, 24'($urandom), random_enable()});
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(wrr_pkg::CFG_SLOT_WEIGHTS, random_weights());
            req_no_idle = ($urandom_range(0, 3) == 0);
            res_no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 2)
                res_hold_due = 1'b1;
            repeat ($urandom_range(20, 60)) send_request($urandom_range(0, 9) != 0);
            phase++;
        end
        drain_results();

        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
